### design/fsbh_pkg.sv
package fsbh_pkg;

    // Timebase ticks per microsecond and reset value of the DATA-wait timeout.
    localparam int unsigned TICKS_PER_US_DEF = 2;
    localparam logic [15:0] TIMEOUT_RESET    = 16'd2000;

    localparam int unsigned ELAPSED_W = 16;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_RX_WAIT = 3'd1,
        PH_RX_RUN  = 3'd2,
        PH_TX_WAIT = 3'd3,
        PH_TX_RUN  = 3'd4,
        PH_TX_ACK  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_RX    = 2'd1,
        ACT_TX    = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ATN     = 2'd1,
        ST_REFUSED = 2'd2,
        ST_TIMEOUT = 2'd3
    } t_status;

    // Count class of the byte being sent.
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_LAST = 2'd1;
    localparam logic [1:0] CNT_MORE = 2'd2;

    // One result word; the last member sits in the lowest bits.
    typedef struct packed {
        logic       consume_byte;
        logic       received_eoi;
        logic [7:0] received_byte;
        t_status    status;
        logic       done_res;
        logic       busy_res;
        logic       data_drive;
        logic       clk_drive;
    } t_result;

endpackage

### design/fast_serial_byte_handshake.sv
// Channel     Direction  Payload
// s_axis      in         tuser: action; tdata: line samples and byte to send
// m_axis      out        tdata: line drives, busy, done, status, received byte
// cfg         in         i_cfg_wr_data: DATA-wait timeout in ticks
//
// Every accepted request is one bus tick and yields one result in the same
// cycle into a two-entry output queue, so one request per clock is sustained while m_axis drains the queue.
// The sequencer state and the queue are the only registers on the path.
// s_axis_tready drops only when both queue entries hold unread results.
// Reset (synchronous, active low) returns the sequencer to idle with both
// lines released and the timeout at 2000 ticks.
module fast_serial_byte_handshake #(
    parameter int unsigned P_TICKS_PER_US = fsbh_pkg::TICKS_PER_US_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    // [0] clk_level, [1] data_level, [2] atn_level, [10:3] send_byte,
    // [12:11] bytes_available, [13] can_accept, [15:14] zero
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] clk_drive, [1] data_drive, [2] busy_res, [3] done_res,
    // [5:4] status, [13:6] received_byte, [14] received_eoi, [15] consume_byte
    output logic [15:0] m_axis_tdata,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    localparam int unsigned EW = fsbh_pkg::ELAPSED_W;

    localparam logic [EW-1:0] L_RX_P0  = EW'(14 * P_TICKS_PER_US);
    localparam logic [EW-1:0] L_RX_P1  = EW'(27 * P_TICKS_PER_US);
    localparam logic [EW-1:0] L_RX_P2  = EW'(38 * P_TICKS_PER_US);
    localparam logic [EW-1:0] L_RX_P3  = EW'(51 * P_TICKS_PER_US);
    localparam logic [EW-1:0] L_RX_EOI = EW'(64 * P_TICKS_PER_US);
    localparam logic [EW-1:0] L_RX_END = EW'(83 * P_TICKS_PER_US);
    localparam logic [EW-1:0] L_TX_P1  = EW'((33 * P_TICKS_PER_US) / 2);
    localparam logic [EW-1:0] L_TX_P2  = EW'((55 * P_TICKS_PER_US) / 2);
    localparam logic [EW-1:0] L_TX_P3  = EW'(39 * P_TICKS_PER_US);
    localparam logic [EW-1:0] L_TX_ST  = EW'(50 * P_TICKS_PER_US);
    localparam logic [EW-1:0] L_TX_REL = EW'(61 * P_TICKS_PER_US);
    localparam logic [EW-1:0] L_TX_END = EW'(65 * P_TICKS_PER_US);

    // Input fields.
    fsbh_pkg::t_action in_action;
    logic       in_clk;
    logic       in_dat;
    logic       in_atn;
    logic [7:0] in_byte;
    logic [1:0] in_avail;
    logic       in_accept;

    assign in_action = fsbh_pkg::t_action'(s_axis_tuser);
    assign in_clk    = s_axis_tdata[0];
    assign in_dat    = s_axis_tdata[1];
    assign in_atn    = s_axis_tdata[2];
    assign in_byte   = s_axis_tdata[10:3];
    assign in_avail  = s_axis_tdata[12:11];
    assign in_accept = s_axis_tdata[13];

    // Sequencer state.
    fsbh_pkg::t_phase r_phase, n_phase;
    logic [EW-1:0] r_elapsed, n_elapsed;
    logic [7:0]    r_shift, n_shift;
    logic          r_eoi, n_eoi;
    logic [1:0]    r_cnt_class, n_cnt_class;
    logic          r_acc_latch, n_acc_latch;
    logic          r_clk_out, n_clk_out;
    logic          r_data_out, n_data_out;
    logic [15:0]   r_timeout;

    // Output queue.
    fsbh_pkg::t_result r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_q_cnt;

    fsbh_pkg::t_result n_res;
    logic          push;
    logic          pop;
    logic [EW-1:0] elapsed_inc;
    logic          rx_wait_hit;
    logic          tx_wait_hit;

    assign s_axis_tready = (r_q_cnt != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_q_cnt != 2'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = r_buf[r_rd_ptr];

    assign elapsed_inc = (r_elapsed != {EW{1'b1}}) ? r_elapsed + EW'(1) : r_elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= fsbh_pkg::TIMEOUT_RESET;
        end else if (i_cfg_wr_en) begin
            r_timeout <= i_cfg_wr_data;
        end
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            fsbh_pkg::PH_IDLE: begin
                if (in_action == fsbh_pkg::ACT_RX) begin
                    n_phase = fsbh_pkg::PH_RX_WAIT;
                end else if (in_action == fsbh_pkg::ACT_TX) begin
                    n_phase = fsbh_pkg::PH_TX_WAIT;
                end
            end
            fsbh_pkg::PH_RX_WAIT: begin
                if (!in_atn) begin
                    n_phase = fsbh_pkg::PH_IDLE;
                end else if (in_clk) begin
                    n_phase = fsbh_pkg::PH_RX_RUN;
                end
            end
            fsbh_pkg::PH_RX_RUN: begin
                if (elapsed_inc >= L_RX_END && elapsed_inc != L_RX_P0
                        && elapsed_inc != L_RX_P1 && elapsed_inc != L_RX_P2
                        && elapsed_inc != L_RX_P3 && elapsed_inc != L_RX_EOI) begin
                    n_phase = fsbh_pkg::PH_IDLE;
                end
            end
            fsbh_pkg::PH_TX_WAIT: begin
                if (!in_atn) begin
                    n_phase = fsbh_pkg::PH_IDLE;
                end else if (in_dat) begin
                    n_phase = fsbh_pkg::PH_TX_RUN;
                end
            end
            fsbh_pkg::PH_TX_RUN: begin
                if (elapsed_inc == L_TX_P1 || elapsed_inc == L_TX_P2
                        || elapsed_inc == L_TX_P3 || elapsed_inc == L_TX_ST) begin
                    n_phase = fsbh_pkg::PH_TX_RUN;
                end else if (elapsed_inc == L_TX_REL) begin
                    if (r_cnt_class != fsbh_pkg::CNT_LAST) begin
                        n_phase = fsbh_pkg::PH_TX_ACK;
                    end
                end else if (elapsed_inc >= L_TX_END) begin
                    n_phase = fsbh_pkg::PH_TX_ACK;
                end
            end
            fsbh_pkg::PH_TX_ACK: begin
                if (!in_atn || !in_dat || elapsed_inc >= r_timeout) begin
                    n_phase = fsbh_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = fsbh_pkg::PH_IDLE;
            end
        endcase
    end

    assign rx_wait_hit = in_atn && in_clk;
    assign tx_wait_hit = in_atn && in_dat;

    // Datapath updates and the result word.
    always_comb begin
        n_elapsed   = r_elapsed;
        n_shift     = r_shift;
        n_eoi       = r_eoi;
        n_cnt_class = r_cnt_class;
        n_acc_latch = r_acc_latch;
        n_clk_out   = r_clk_out;
        n_data_out  = r_data_out;
        n_res       = '0;
        case (r_phase)
            fsbh_pkg::PH_IDLE: begin
                if (in_action == fsbh_pkg::ACT_RX) begin
                    n_acc_latch = in_accept;
                    n_shift     = '0;
                    n_eoi       = 1'b0;
                    n_elapsed   = '0;
                    n_data_out  = 1'b1;
                end else if (in_action == fsbh_pkg::ACT_TX) begin
                    // A count of three is treated as more to follow.
                    n_cnt_class = (in_avail == fsbh_pkg::CNT_NONE) ? fsbh_pkg::CNT_NONE :
                                  (in_avail == fsbh_pkg::CNT_LAST) ? fsbh_pkg::CNT_LAST :
                                  fsbh_pkg::CNT_MORE;
                    n_shift     = (in_avail != fsbh_pkg::CNT_NONE) ? in_byte : 8'd0;
                    n_eoi       = 1'b0;
                    n_elapsed   = '0;
                    n_clk_out   = 1'b1;
                end
            end
            fsbh_pkg::PH_RX_WAIT: begin
                if (!in_atn) begin
                    n_res.done_res = 1'b1;
                    n_res.status   = fsbh_pkg::ST_ATN;
                end else if (rx_wait_hit) begin
                    n_elapsed = '0;
                end
            end
            fsbh_pkg::PH_RX_RUN: begin
                n_elapsed = elapsed_inc;
                if (elapsed_inc == L_RX_P0) begin
                    n_shift = r_shift | {2'b0, ~in_dat, ~in_clk, 4'b0};
                end else if (elapsed_inc == L_RX_P1) begin
                    n_shift = r_shift | {~in_dat, ~in_clk, 6'b0};
                end else if (elapsed_inc == L_RX_P2) begin
                    n_shift = r_shift | {4'b0, ~in_clk, 1'b0, ~in_dat, 1'b0};
                end else if (elapsed_inc == L_RX_P3) begin
                    n_shift = r_shift | {5'b0, ~in_clk, 1'b0, ~in_dat};
                end else if (elapsed_inc == L_RX_EOI) begin
                    n_eoi      = in_clk;
                    n_data_out = 1'b0;
                end else if (elapsed_inc >= L_RX_END) begin
                    n_res.done_res      = 1'b1;
                    n_res.status        = r_acc_latch ? fsbh_pkg::ST_OK
                                                      : fsbh_pkg::ST_REFUSED;
                    n_res.received_byte = r_shift;
                    n_res.received_eoi  = r_eoi;
                end
            end
            fsbh_pkg::PH_TX_WAIT: begin
                if (!in_atn) begin
                    n_res.done_res = 1'b1;
                    n_res.status   = fsbh_pkg::ST_ATN;
                end else if (tx_wait_hit) begin
                    n_elapsed  = '0;
                    n_clk_out  = r_shift[0];
                    n_data_out = r_shift[1];
                end
            end
            fsbh_pkg::PH_TX_RUN: begin
                n_elapsed = elapsed_inc;
                if (elapsed_inc == L_TX_P1) begin
                    n_clk_out  = r_shift[2];
                    n_data_out = r_shift[3];
                end else if (elapsed_inc == L_TX_P2) begin
                    n_clk_out  = r_shift[4];
                    n_data_out = r_shift[5];
                end else if (elapsed_inc == L_TX_P3) begin
                    n_clk_out  = r_shift[6];
                    n_data_out = r_shift[7];
                end else if (elapsed_inc == L_TX_ST) begin
                    // More: CLK low. Last: DATA low. No data: both released.
                    if (r_cnt_class == fsbh_pkg::CNT_MORE) begin
                        n_clk_out  = 1'b0;
                        n_data_out = 1'b1;
                    end else begin
                        n_clk_out  = 1'b1;
                        n_data_out = (r_cnt_class == fsbh_pkg::CNT_NONE);
                    end
                end else if (elapsed_inc == L_TX_REL) begin
                    if (r_cnt_class == fsbh_pkg::CNT_LAST) begin
                        n_data_out = 1'b1;
                    end else begin
                        n_elapsed = '0;
                    end
                end else if (elapsed_inc >= L_TX_END) begin
                    n_elapsed = '0;
                end
            end
            fsbh_pkg::PH_TX_ACK: begin
                if (!in_atn) begin
                    n_res.done_res = 1'b1;
                    n_res.status   = fsbh_pkg::ST_ATN;
                end else if (!in_dat) begin
                    n_res.done_res = 1'b1;
                    if (r_cnt_class != fsbh_pkg::CNT_NONE) begin
                        n_res.consume_byte = 1'b1;
                    end else begin
                        n_res.status = fsbh_pkg::ST_REFUSED;
                    end
                end else begin
                    n_elapsed = elapsed_inc;
                    if (elapsed_inc >= r_timeout) begin
                        n_res.done_res = 1'b1;
                        n_res.status   = fsbh_pkg::ST_TIMEOUT;
                    end
                end
            end
            default: begin
                n_res = '0;
            end
        endcase
        n_res.clk_drive  = n_clk_out;
        n_res.data_drive = n_data_out;
        n_res.busy_res   = (n_phase != fsbh_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= fsbh_pkg::PH_IDLE;
            r_elapsed   <= '0;
            r_shift     <= '0;
            r_eoi       <= 1'b0;
            r_cnt_class <= fsbh_pkg::CNT_NONE;
            r_acc_latch <= 1'b0;
            r_clk_out   <= 1'b1;
            r_data_out  <= 1'b1;
        end else if (push) begin
            r_phase     <= n_phase;
            r_elapsed   <= n_elapsed;
            r_shift     <= n_shift;
            r_eoi       <= n_eoi;
            r_cnt_class <= n_cnt_class;
            r_acc_latch <= n_acc_latch;
            r_clk_out   <= n_clk_out;
            r_data_out  <= n_data_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_q_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_q_cnt <= r_q_cnt + 2'd1;
                2'b01:   r_q_cnt <= r_q_cnt - 2'd1;
                default: r_q_cnt <= r_q_cnt;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt != 2'd3)
        else $error("output queue count out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && n_res.done_res |-> !n_res.busy_res)
        else $error("done result still marked busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && n_res.status != fsbh_pkg::ST_OK |-> n_res.done_res)
        else $error("status set without done");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && n_res.done_res |=> r_phase == fsbh_pkg::PH_IDLE)
        else $error("sequencer not idle after a finished transfer");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && (n_res.consume_byte || n_res.received_eoi) |-> n_res.done_res)
        else $error("transfer result flags outside a done tick");

endmodule
